@@ sv/complex_arithmetic_unit_macros.svh @@
// Assertion macros used by the checker file of the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define CAU_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define CAU_ASSERT_NR(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/cau_pkg.sv @@
// Shared types, codes and constants of the complex arithmetic unit.
package cau_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int FIELD_BITS    = 32;
   localparam int OP_BITS       = 3;
   localparam int STATUS_BITS   = 2;
   localparam int ANG_FRAC      = 24;
   localparam int CORDIC_STEPS  = 28;
   localparam int NORM_EXP      = 40;
   localparam longint DEG90     = 64'd90 << ANG_FRAC;

   localparam logic [OP_BITS-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_BITS-1:0] OP_MUL   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_DIV   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_POLAR = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DIV0 = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_SAT  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_MULT,
      S_POST,
      S_DIVIDE,
      S_DFIN,
      S_SQRT,
      S_SFIN,
      S_NORM,
      S_ROTATE,
      S_AFIN,
      S_DONE
   } state_type;

   // Arctangent of 2^-i in degrees with 24 fraction bits.
   function automatic logic [29:0] atan_deg(input logic [4:0] idx);
      case (idx)
         5'd0:  return 30'd754974720;
         5'd1:  return 30'd445687602;
         5'd2:  return 30'd235489088;
         5'd3:  return 30'd119537938;
         5'd4:  return 30'd60000934;
         5'd5:  return 30'd30029717;
         5'd6:  return 30'd15018523;
         5'd7:  return 30'd7509720;
         5'd8:  return 30'd3754917;
         5'd9:  return 30'd1877466;
         5'd10: return 30'd938734;
         5'd11: return 30'd469367;
         5'd12: return 30'd234684;
         5'd13: return 30'd117342;
         5'd14: return 30'd58671;
         5'd15: return 30'd29335;
         5'd16: return 30'd14668;
         5'd17: return 30'd7334;
         5'd18: return 30'd3667;
         5'd19: return 30'd1833;
         5'd20: return 30'd917;
         5'd21: return 30'd458;
         5'd22: return 30'd229;
         5'd23: return 30'd115;
         5'd24: return 30'd57;
         5'd25: return 30'd29;
         5'd26: return 30'd14;
         5'd27: return 30'd7;
         default: return 30'd0;
      endcase
   endfunction

endpackage

@@ sv/cau_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
interface cau_req_if;
   logic                                valid;
   logic                                ready;
   logic [cau_pkg::OP_BITS-1:0]         op;
   logic                                use_acc;
   logic signed [cau_pkg::FIELD_BITS-1:0] a_re;
   logic signed [cau_pkg::FIELD_BITS-1:0] a_im;
   logic signed [cau_pkg::FIELD_BITS-1:0] b_re;
   logic signed [cau_pkg::FIELD_BITS-1:0] b_im;

   modport source (output valid, op, use_acc, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, op, use_acc, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cau_pkg::FIELD_BITS-1:0] res_re;
   logic signed [cau_pkg::FIELD_BITS-1:0] res_im;
   logic [cau_pkg::STATUS_BITS-1:0]       status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink (input valid, res_re, res_im, status, output ready);
endinterface

@@ sv/complex_arithmetic_unit.sv @@
// Complex ALU with accumulator: serial multiply, divide, square root and CORDIC polar.
// The multiplier, divider and square root work one bit per cycle and the CORDIC one step
// per cycle; one item is in work at a time, the next taken once the previous result sits
// in the output register. Synchronous reset clears the accumulator.
module complex_arithmetic_unit #(
   parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);

   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * W + 2;
   localparam int DW   = 3 * W;
   localparam int RW   = 2 * W + 1;
   localparam int SRW  = W + 3;
   localparam int CW   = 46;
   localparam int ZW   = 34;
   localparam int AW   = ZW + 8;
   localparam int CNTW = ($clog2(W) > 5) ? $clog2(W) : 5;
   localparam int ANG_SHR = (F <= cau_pkg::ANG_FRAC) ? cau_pkg::ANG_FRAC - F : 0;
   localparam int ANG_SHL = (F > cau_pkg::ANG_FRAC) ? F - cau_pkg::ANG_FRAC : 0;
   localparam logic signed [CW-1:0] LIMP = CW'(64'd1 << cau_pkg::NORM_EXP);
   localparam logic signed [ZW-1:0] Z90  = ZW'(cau_pkg::DEG90);

   function automatic logic [W:0] sat_w(input logic neg, input logic [DW-1:0] mag);
      logic [DW-1:0] lim;
      logic [W-1:0]  low;
      lim = DW'(1) << (W - 1);
      low = mag[W-1:0];
      if (neg) begin
         if (mag > lim) return {1'b1, 1'b1, {(W - 1){1'b0}}};
         return {1'b0, W'(-low)};
      end
      if (mag > lim - DW'(1)) return {1'b1, 1'b0, {(W - 1){1'b1}}};
      return {1'b0, low};
   endfunction

   function automatic logic [W:0] sat_sv(input logic signed [DW-1:0] v);
      logic [DW-1:0] m;
      m = v[DW-1] ? unsigned'(-v) : unsigned'(v);
      return sat_w(v[DW-1], m);
   endfunction

   function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
      return v[W-1] ? unsigned'(-v) : unsigned'(v);
   endfunction

   cau_pkg::state_type state_ff, state_in;

   logic [cau_pkg::OP_BITS-1:0] op_ff;
   logic [1:0]                  pass_ff;
   logic signed [W-1:0]         ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [W-1:0]         acc_re_ff, acc_im_ff;
   logic signed [W-1:0]         res_re_ff, res_im_ff;
   logic                        sat_ff, dz_ff;
   logic [2*W-1:0]              mc1_ff, mc2_ff;
   logic [W-1:0]                mp1_ff, mp2_ff;
   logic                        sg1_ff, sg2_ff;
   logic signed [PW-1:0]        macc_ff;
   logic [CNTW-1:0]             cnt_ff;
   logic [2*W-1:0]              den_ff;
   logic [RW-1:0]               rem_ff;
   logic [W-1:0]                dl_ff;
   logic                        nneg_ff;
   logic [2*W-1:0]              sq_ff;
   logic [W-1:0]                root_ff;
   logic [SRW-1:0]              srem_ff;
   logic signed [CW-1:0]        x_ff, y_ff;
   logic signed [ZW-1:0]        z_ff;
   logic                        rsp_valid_ff;
   logic signed [cau_pkg::FIELD_BITS-1:0] rsp_re_ff, rsp_im_ff;
   logic [cau_pkg::STATUS_BITS-1:0]       rsp_status_ff;

   logic signed [W-1:0] x1, y1, x2, y2;
   logic                n1, n2;
   logic signed [PW-1:0] t1, t2;
   logic                macc_neg;
   logic [PW-1:0]       macc_mag, mul_rnd;
   logic [W:0]          mul_res;
   logic signed [W:0]   sum_re, sum_im;
   logic [W:0]          as_re, as_im;
   logic [DW-1:0]       divd, div_hi;
   logic                div_ovf;
   logic [W:0]          div_ovf_res;
   logic [RW-1:0]       r2;
   logic                r2_ge;
   logic [W:0]          q_rnd, dfin_res;
   logic [SRW+1:0]      sq_t, sq_trial;
   logic                sq_ge;
   logic [W:0]          smag, sfin_res;
   logic                pt_zero, norm_more;
   logic signed [CW-1:0] xa, ya, dx, dy;
   logic signed [ZW-1:0] atan_v;
   logic [ZW-1:0]       zmag;
   logic [AW-1:0]       aconv;
   logic [W:0]          afin_res;
   logic                last_bit, last_rot;
   logic                req_ready, req_fire, done_fire;
   logic                req_long;

   // Operand pairs for each dot-product pass.
   always_comb begin
      x1 = ar_ff;
      y1 = ar_ff;
      n1 = 1'b0;
      x2 = ai_ff;
      y2 = ai_ff;
      n2 = 1'b0;
      case (op_ff)
         cau_pkg::OP_MUL: begin
            if (pass_ff == 2'd0) begin
               y1 = br_ff;
               y2 = bi_ff;
               n2 = 1'b1;
            end else begin
               y1 = bi_ff;
               y2 = br_ff;
            end
         end
         cau_pkg::OP_DIV: begin
            if (pass_ff == 2'd0) begin
               x1 = br_ff;
               y1 = br_ff;
               x2 = bi_ff;
               y2 = bi_ff;
            end else if (pass_ff == 2'd1) begin
               y1 = br_ff;
               y2 = bi_ff;
            end else begin
               x1 = ai_ff;
               y1 = br_ff;
               x2 = ar_ff;
               y2 = bi_ff;
               n2 = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      t1 = '0;
      t2 = '0;
      if (mp1_ff[0]) t1 = sg1_ff ? -$signed({2'b00, mc1_ff}) : $signed({2'b00, mc1_ff});
      if (mp2_ff[0]) t2 = sg2_ff ? -$signed({2'b00, mc2_ff}) : $signed({2'b00, mc2_ff});

      macc_neg = macc_ff[PW-1];
      macc_mag = macc_neg ? unsigned'(-macc_ff) : unsigned'(macc_ff);
      mul_rnd  = ((macc_mag >> (F - 1)) + PW'(1)) >> 1;
      mul_res  = sat_w(macc_neg, DW'(mul_rnd));

      if (op_ff == cau_pkg::OP_SUB) begin
         sum_re = (W + 1)'(ar_ff) - (W + 1)'(br_ff);
         sum_im = (W + 1)'(ai_ff) - (W + 1)'(bi_ff);
      end else begin
         sum_re = (W + 1)'(ar_ff) + (W + 1)'(br_ff);
         sum_im = (W + 1)'(ai_ff) + (W + 1)'(bi_ff);
      end
      as_re = sat_sv(DW'(sum_re));
      as_im = sat_sv(DW'(sum_im));

      divd        = DW'(macc_mag) << F;
      div_hi      = divd >> W;
      div_ovf     = div_hi >= DW'(den_ff);
      div_ovf_res = sat_w(macc_neg, '1);

      r2       = {rem_ff[RW-2:0], dl_ff[W-1]};
      r2_ge    = r2 >= RW'(den_ff);
      q_rnd    = (W + 1)'(dl_ff) + (W + 1)'({rem_ff, 1'b0} >= (RW + 1)'(den_ff));
      dfin_res = sat_w(nneg_ff, DW'(q_rnd));

      sq_t     = {srem_ff, sq_ff[2*W-1 -: 2]};
      sq_trial = (SRW + 2)'({root_ff, 2'b01});
      sq_ge    = sq_t >= sq_trial;
      smag     = (W + 1)'(root_ff) + (W + 1)'(srem_ff > SRW'(root_ff));
      sfin_res = sat_w(1'b0, DW'(smag));

      pt_zero   = (ar_ff == '0) && (ai_ff == '0);
      xa        = CW'(ar_ff);
      ya        = CW'(ai_ff);
      norm_more = (x_ff < LIMP) && (x_ff > -LIMP) && (y_ff < LIMP) && (y_ff > -LIMP);
      dx        = y_ff >>> cnt_ff;
      dy        = x_ff >>> cnt_ff;
      atan_v    = signed'(ZW'(cau_pkg::atan_deg(cnt_ff[4:0])));

      zmag     = z_ff[ZW-1] ? unsigned'(-z_ff) : unsigned'(z_ff);
      aconv    = ((((AW'(zmag) << 1) >> ANG_SHR) + AW'(1)) >> 1) << ANG_SHL;
      afin_res = sat_w(z_ff[ZW-1], DW'(aconv));

      last_bit = cnt_ff == CNTW'(W - 1);
      last_rot = cnt_ff == CNTW'(cau_pkg::CORDIC_STEPS - 1);
      req_long = (req_chan.op == cau_pkg::OP_MUL) || (req_chan.op == cau_pkg::OP_DIV) ||
                 (req_chan.op == cau_pkg::OP_POLAR);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cau_pkg::S_IDLE: begin
            if (req_fire) state_in = req_long ? cau_pkg::S_LOAD : cau_pkg::S_POST;
         end
         cau_pkg::S_LOAD: state_in = cau_pkg::S_MULT;
         cau_pkg::S_MULT: begin
            if (last_bit) state_in = cau_pkg::S_POST;
         end
         cau_pkg::S_POST: begin
            case (op_ff)
               cau_pkg::OP_MUL: begin
                  state_in = (pass_ff == 2'd0) ? cau_pkg::S_LOAD : cau_pkg::S_DONE;
               end
               cau_pkg::OP_DIV: begin
                  if (pass_ff == 2'd0) begin
                     state_in = (macc_ff == '0) ? cau_pkg::S_DONE : cau_pkg::S_LOAD;
                  end else if (div_ovf) begin
                     state_in = (pass_ff == 2'd1) ? cau_pkg::S_LOAD : cau_pkg::S_DONE;
                  end else begin
                     state_in = cau_pkg::S_DIVIDE;
                  end
               end
               cau_pkg::OP_POLAR: state_in = cau_pkg::S_SQRT;
               default: state_in = cau_pkg::S_DONE;
            endcase
         end
         cau_pkg::S_DIVIDE: begin
            if (last_bit) state_in = cau_pkg::S_DFIN;
         end
         cau_pkg::S_DFIN: begin
            state_in = (pass_ff == 2'd1) ? cau_pkg::S_LOAD : cau_pkg::S_DONE;
         end
         cau_pkg::S_SQRT: begin
            if (last_bit) state_in = cau_pkg::S_SFIN;
         end
         cau_pkg::S_SFIN: state_in = pt_zero ? cau_pkg::S_DONE : cau_pkg::S_NORM;
         cau_pkg::S_NORM: begin
            if (!norm_more) state_in = cau_pkg::S_ROTATE;
         end
         cau_pkg::S_ROTATE: begin
            if (last_rot) state_in = cau_pkg::S_AFIN;
         end
         cau_pkg::S_AFIN: state_in = cau_pkg::S_DONE;
         cau_pkg::S_DONE: begin
            if (done_fire) state_in = cau_pkg::S_IDLE;
         end
         default: state_in = cau_pkg::S_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ready = state_ff == cau_pkg::S_IDLE;
      req_fire  = req_ready && req_chan.valid;
      done_fire = (state_ff == cau_pkg::S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign req_chan.ready  = req_ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.res_re = rsp_re_ff;
   assign rsp_chan.res_im = rsp_im_ff;
   assign rsp_chan.status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cau_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
            case (op_ff)
               cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_DIV: begin
                  if (!dz_ff) begin
                     acc_re_ff <= res_re_ff;
                     acc_im_ff <= res_im_ff;
                  end
               end
               cau_pkg::OP_POLAR: begin
                  acc_re_ff <= ar_ff;
                  acc_im_ff <= ai_ff;
               end
               default: begin
               end
            endcase
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_re_ff     <= cau_pkg::FIELD_BITS'(res_re_ff);
         rsp_im_ff     <= cau_pkg::FIELD_BITS'(res_im_ff);
         rsp_status_ff <= dz_ff ? cau_pkg::ST_DIV0 : (sat_ff ? cau_pkg::ST_SAT : cau_pkg::ST_OK);
      end
   end

   // Datapath of the sequencer.
   always_ff @(posedge clock) begin
      case (state_ff)
         cau_pkg::S_IDLE: begin
            if (req_fire) begin
               op_ff   <= req_chan.op;
               ar_ff   <= req_chan.use_acc ? acc_re_ff : signed'(req_chan.a_re[W-1:0]);
               ai_ff   <= req_chan.use_acc ? acc_im_ff : signed'(req_chan.a_im[W-1:0]);
               br_ff   <= signed'(req_chan.b_re[W-1:0]);
               bi_ff   <= signed'(req_chan.b_im[W-1:0]);
               sat_ff  <= 1'b0;
               dz_ff   <= 1'b0;
               pass_ff <= 2'd0;
            end
         end
         cau_pkg::S_LOAD: begin
            mc1_ff  <= (2 * W)'(mag_w(x1));
            mc2_ff  <= (2 * W)'(mag_w(x2));
            mp1_ff  <= mag_w(y1);
            mp2_ff  <= mag_w(y2);
            sg1_ff  <= n1 ^ x1[W-1] ^ y1[W-1];
            sg2_ff  <= n2 ^ x2[W-1] ^ y2[W-1];
            macc_ff <= '0;
            cnt_ff  <= '0;
         end
         cau_pkg::S_MULT: begin
            macc_ff <= macc_ff + t1 + t2;
            mc1_ff  <= mc1_ff << 1;
            mc2_ff  <= mc2_ff << 1;
            mp1_ff  <= mp1_ff >> 1;
            mp2_ff  <= mp2_ff >> 1;
            cnt_ff  <= cnt_ff + CNTW'(1);
         end
         cau_pkg::S_POST: begin
            case (op_ff)
               cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                  res_re_ff <= signed'(as_re[W-1:0]);
                  res_im_ff <= signed'(as_im[W-1:0]);
                  sat_ff    <= as_re[W] | as_im[W];
               end
               cau_pkg::OP_MUL: begin
                  if (pass_ff == 2'd0) begin
                     res_re_ff <= signed'(mul_res[W-1:0]);
                     pass_ff   <= 2'd1;
                  end else begin
                     res_im_ff <= signed'(mul_res[W-1:0]);
                  end
                  sat_ff <= sat_ff | mul_res[W];
               end
               cau_pkg::OP_DIV: begin
                  if (pass_ff == 2'd0) begin
                     den_ff <= macc_ff[2*W-1:0];
                     if (macc_ff == '0) begin
                        dz_ff     <= 1'b1;
                        res_re_ff <= '0;
                        res_im_ff <= '0;
                     end else begin
                        pass_ff <= 2'd1;
                     end
                  end else if (div_ovf) begin
                     if (pass_ff == 2'd1) begin
                        res_re_ff <= signed'(div_ovf_res[W-1:0]);
                        pass_ff   <= 2'd2;
                     end else begin
                        res_im_ff <= signed'(div_ovf_res[W-1:0]);
                     end
                     sat_ff <= 1'b1;
                  end else begin
                     rem_ff  <= div_hi[RW-1:0];
                     dl_ff   <= divd[W-1:0];
                     nneg_ff <= macc_neg;
                     cnt_ff  <= '0;
                  end
               end
               cau_pkg::OP_POLAR: begin
                  sq_ff   <= macc_ff[2*W-1:0];
                  root_ff <= '0;
                  srem_ff <= '0;
                  cnt_ff  <= '0;
               end
               default: begin
                  res_re_ff <= acc_re_ff;
                  res_im_ff <= acc_im_ff;
               end
            endcase
         end
         cau_pkg::S_DIVIDE: begin
            rem_ff <= r2_ge ? r2 - RW'(den_ff) : r2;
            dl_ff  <= {dl_ff[W-2:0], r2_ge};
            cnt_ff <= cnt_ff + CNTW'(1);
         end
         cau_pkg::S_DFIN: begin
            if (pass_ff == 2'd1) begin
               res_re_ff <= signed'(dfin_res[W-1:0]);
               pass_ff   <= 2'd2;
            end else begin
               res_im_ff <= signed'(dfin_res[W-1:0]);
            end
            sat_ff <= sat_ff | dfin_res[W];
         end
         cau_pkg::S_SQRT: begin
            srem_ff <= SRW'(sq_ge ? sq_t - sq_trial : sq_t);
            root_ff <= {root_ff[W-2:0], sq_ge};
            sq_ff   <= sq_ff << 2;
            cnt_ff  <= cnt_ff + CNTW'(1);
         end
         cau_pkg::S_SFIN: begin
            res_re_ff <= signed'(sfin_res[W-1:0]);
            sat_ff    <= sat_ff | sfin_res[W];
            if (pt_zero) res_im_ff <= '0;
            if (ar_ff < 0) begin
               if (ai_ff >= 0) begin
                  x_ff <= ya;
                  y_ff <= -xa;
                  z_ff <= Z90;
               end else begin
                  x_ff <= -ya;
                  y_ff <= xa;
                  z_ff <= -Z90;
               end
            end else begin
               x_ff <= xa;
               y_ff <= ya;
               z_ff <= '0;
            end
         end
         cau_pkg::S_NORM: begin
            if (norm_more) begin
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
            end else begin
               cnt_ff <= '0;
            end
         end
         cau_pkg::S_ROTATE: begin
            if (y_ff > 0) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + atan_v;
            end else if (y_ff < 0) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - atan_v;
            end
            cnt_ff <= cnt_ff + CNTW'(1);
         end
         cau_pkg::S_AFIN: begin
            res_im_ff <= signed'(afin_res[W-1:0]);
            sat_ff    <= sat_ff | afin_res[W];
         end
         default: begin
         end
      endcase
   end

endmodule

@@ sv/cau_checker.sv @@
// Port-level checker of the complex arithmetic unit and its bind.
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [cau_pkg::FIELD_BITS-1:0] rsp_res_re,
   input logic signed [cau_pkg::FIELD_BITS-1:0] rsp_res_im,
   input logic [cau_pkg::STATUS_BITS-1:0]       rsp_status
);

   `CAU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_re) && $stable(rsp_res_im) && $stable(rsp_status), "Stalled response changed.")
   `CAU_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "Unit not idle after reset.")
   `CAU_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "Request taken while an item is in work.")
   `CAU_ASSERT(a_div0_zero, clock, reset, rsp_valid && rsp_status == cau_pkg::ST_DIV0 |-> rsp_res_re == 0 && rsp_res_im == 0, "Divide by zero result is not zero.")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_res_re (rsp_chan.res_re),
   .rsp_res_im (rsp_chan.res_im),
   .rsp_status (rsp_chan.status)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the complex arithmetic unit with predicted results.
module tb_top;

   typedef struct packed {
      logic [cau_pkg::OP_BITS-1:0] op;
      logic                        use_acc;
      logic signed [31:0]          a_re;
      logic signed [31:0]          a_im;
      logic signed [31:0]          b_re;
      logic signed [31:0]          b_im;
   } calc_item_type;

   typedef struct packed {
      logic signed [31:0]              res_re;
      logic signed [31:0]              res_im;
      logic [cau_pkg::STATUS_BITS-1:0] status;
   } calc_result_type;

   localparam logic [cau_pkg::OP_BITS-1:0] OP_SPARE5 = 3'd5;
   localparam logic [cau_pkg::OP_BITS-1:0] OP_SPARE6 = 3'd6;
   localparam logic [cau_pkg::OP_BITS-1:0] OP_SPARE7 = 3'd7;
   localparam int FRAC = cau_pkg::FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam longint ATAN_DEG_Q24 [cau_pkg::CORDIC_STEPS] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

   logic clock;
   logic reset;

   cau_req_if req_bus ();
   cau_rsp_if rsp_bus ();

   complex_arithmetic_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   calc_item_type   pending_items[$];
   calc_result_type expected_results[$];
   longint          acc_re_model;
   longint          acc_im_model;
   bit              saturated;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              error_count;
   int              quiet_cycles;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic signed [131:0] round_shift(input logic signed [131:0] v,
                                                       input int n);
      logic [131:0] mag;
      mag = v < 0 ? -v : v;
      mag = (mag >> n) + ((mag >> (n - 1)) & 132'd1);
      return v < 0 ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic longint clamp_word(input logic signed [131:0] v);
      if (v > 132'sd2147483647) begin
         saturated = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -132'sd2147483648) begin
         saturated = 1'b1;
         return -64'sd2147483648;
      end
      return longint'(v);
   endfunction

   function automatic logic signed [131:0] divide_round(input logic signed [131:0] n,
                                                        input logic [131:0] d);
      logic [131:0] mag;
      logic [131:0] quo;
      logic [131:0] rem;
      mag = n < 0 ? -n : n;
      mag = mag << FRAC;
      quo = mag / d;
      rem = mag % d;
      if (rem >= d - rem) quo = quo + 1;
      return n < 0 ? -$signed(quo) : $signed(quo);
   endfunction

   function automatic longint unsigned root_round(input longint unsigned s);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      if (s > root) root = root + 1;
      return root;
   endfunction

   function automatic longint angle_deg_q24(input longint x, input longint y);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = cau_pkg::DEG90;
         end else begin
            x = -y;
            y = t;
            z = -cau_pkg::DEG90;
         end
      end
      while ((x < 0 ? -x : x) < (64'sd1 <<< cau_pkg::NORM_EXP) &&
             (y < 0 ? -y : y) < (64'sd1 <<< cau_pkg::NORM_EXP)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < cau_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_DEG_Q24[i];
         end else if (y < 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_DEG_Q24[i];
         end
      end
      return z;
   endfunction

   function automatic calc_result_type compute_result(input calc_item_type it);
      logic signed [131:0] ar, ai, br, bi, s;
      logic [131:0]        den;
      longint              rr, ri;
      calc_result_type     r;
      saturated = 1'b0;
      ar = it.use_acc ? acc_re_model : it.a_re;
      ai = it.use_acc ? acc_im_model : it.a_im;
      br = it.b_re;
      bi = it.b_im;
      r.status = cau_pkg::ST_OK;
      rr = 0;
      ri = 0;
      case (it.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
            if (it.op == cau_pkg::OP_ADD) begin
               rr = clamp_word(ar + br);
               ri = clamp_word(ai + bi);
            end else if (it.op == cau_pkg::OP_SUB) begin
               rr = clamp_word(ar - br);
               ri = clamp_word(ai - bi);
            end else begin
               rr = clamp_word(round_shift(ar * br - ai * bi, FRAC));
               ri = clamp_word(round_shift(ar * bi + ai * br, FRAC));
            end
            acc_re_model = rr;
            acc_im_model = ri;
         end
         cau_pkg::OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.status = cau_pkg::ST_DIV0;
            end else begin
               rr = clamp_word(divide_round(ar * br + ai * bi, den));
               ri = clamp_word(divide_round(ai * br - ar * bi, den));
               acc_re_model = rr;
               acc_im_model = ri;
            end
         end
         cau_pkg::OP_POLAR: begin
            s = ar * ar + ai * ai;
            rr = clamp_word(root_round(longint'(s)));
            ri = clamp_word(round_shift(angle_deg_q24(longint'(ar), longint'(ai)),
                                        cau_pkg::ANG_FRAC - FRAC));
            acc_re_model = longint'(ar);
            acc_im_model = longint'(ai);
         end
         default: begin
            rr = acc_re_model;
            ri = acc_im_model;
         end
      endcase
      if (r.status == cau_pkg::ST_OK && saturated) r.status = cau_pkg::ST_SAT;
      r.res_re = rr[31:0];
      r.res_im = ri[31:0];
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3ffff)
                                        : -$urandom_range(0, 32'h3ffff);
         3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3ffffff)
                                        : -$urandom_range(0, 32'h3ffffff);
         4: return $urandom_range(0, 1) ? 32'sd65536 * $urandom_range(0, 40)
                                        : -32'sd65536 * $urandom_range(0, 40);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h80000000;
               1: return 32'h7fffffff;
               2: return 32'hffffffff;
               3: return 32'h00010000;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   function automatic calc_item_type random_item();
      calc_item_type it;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 20) it.op = cau_pkg::OP_ADD;
      else if (sel < 38) it.op = cau_pkg::OP_SUB;
      else if (sel < 60) it.op = cau_pkg::OP_MUL;
      else if (sel < 80) it.op = cau_pkg::OP_DIV;
      else if (sel < 95) it.op = cau_pkg::OP_POLAR;
      else it.op = 3'($urandom_range(5, 7));
      it.use_acc = $urandom_range(0, 99) < 35;
      it.a_re = pick_word();
      it.a_im = pick_word();
      it.b_re = pick_word();
      it.b_im = pick_word();
      if ($urandom_range(0, 19) == 0) begin
         it.b_re = 0;
         it.b_im = 0;
      end
      return it;
   endfunction

   task automatic queue_item(input logic [cau_pkg::OP_BITS-1:0] op, input logic use_acc,
                             input logic [31:0] a_re, input logic [31:0] a_im,
                             input logic [31:0] b_re, input logic [31:0] b_im);
      calc_item_type it;
      it.op = op;
      it.use_acc = use_acc;
      it.a_re = a_re;
      it.a_im = a_im;
      it.b_re = b_re;
      it.b_im = b_im;
      pending_items.push_back(it);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            calc_item_type it;
            it = pending_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.op <= it.op;
            req_bus.use_acc <= it.use_acc;
            req_bus.a_re <= it.a_re;
            req_bus.a_im <= it.a_im;
            req_bus.b_re <= it.b_re;
            req_bus.b_im <= it.b_im;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= $urandom_range(0, 99) >= recv_stall_pct;
   end

   always @(posedge clock) begin
      calc_item_type   it;
      calc_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            it.op = req_bus.op;
            it.use_acc = req_bus.use_acc;
            it.a_re = req_bus.a_re;
            it.a_im = req_bus.a_im;
            it.b_re = req_bus.b_re;
            it.b_im = req_bus.b_im;
            expected_results.push_back(compute_result(it));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_bus.res_re, 32'h0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.res_re !== want.res_re)
                  report_mismatch("res_re", rsp_bus.res_re, want.res_re);
               if (rsp_bus.res_im !== want.res_im)
                  report_mismatch("res_im", rsp_bus.res_im, want.res_im);
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_results.size());
         $display("complex_arithmetic_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = cau_pkg::OP_ADD;
      req_bus.use_acc = 1'b0;
      req_bus.a_re = 0;
      req_bus.a_im = 0;
      req_bus.b_re = 0;
      req_bus.b_im = 0;
      rsp_bus.ready = 1'b0;
      acc_re_model = 0;
      acc_im_model = 0;
      error_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 9;
      recv_stall_pct = 52;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_item(cau_pkg::OP_ADD, 1'b1, 0, 0, 32'h00018000, 32'hfffe8000);
      queue_item(cau_pkg::OP_ADD, 1'b0, 32'h7fffffff, 32'h80000000, 32'h00000001,
                 32'hffffffff);
      queue_item(cau_pkg::OP_SUB, 1'b0, 32'h80000000, 32'h7fffffff, 32'h00000001,
                 32'hffffffff);
      queue_item(cau_pkg::OP_SUB, 1'b1, 0, 0, 32'h00010000, 32'h00020000);
      queue_item(cau_pkg::OP_MUL, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000);
      queue_item(cau_pkg::OP_MUL, 1'b0, 32'h00000001, 32'h00000000, 32'h00008000,
                 32'h00000000);
      queue_item(cau_pkg::OP_MUL, 1'b0, 32'hffffffff, 32'h00000000, 32'h00008000,
                 32'h00000000);
      queue_item(cau_pkg::OP_MUL, 1'b1, 0, 0, 32'h00030000, 32'hfffd0000);
      queue_item(cau_pkg::OP_DIV, 1'b0, 32'h00050000, 32'h00020000, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_DIV, 1'b0, 32'h00050000, 32'hfffe0000, 32'h00010000,
                 32'h00030000);
      queue_item(cau_pkg::OP_DIV, 1'b0, 32'h7fffffff, 32'h80000000, 32'h00000001,
                 32'h00000000);
      queue_item(cau_pkg::OP_DIV, 1'b1, 0, 0, 32'hffff0000, 32'h00000001);
      queue_item(cau_pkg::OP_POLAR, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_POLAR, 1'b0, 32'hfffd0000, 32'h00040000, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_POLAR, 1'b0, 32'hfffd0000, 32'hfffc0000, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_POLAR, 1'b0, 32'hffff0000, 32'h0, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_POLAR, 1'b0, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_POLAR, 1'b0, 32'h7fffffff, 32'h00000001, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_POLAR, 1'b1, 0, 0, 32'h0, 32'h0);
      queue_item(OP_SPARE5, 1'b0, 32'h12345678, 32'h9abcdef0, 32'h0, 32'h0);
      queue_item(OP_SPARE6, 1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      queue_item(OP_SPARE7, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
      queue_item(cau_pkg::OP_ADD, 1'b1, 0, 0, 32'h0, 32'h0);
      for (int i = 0; i < 620; i++) pending_items.push_back(random_item());
      wait_drained();

      send_idle_pct = 52;
      recv_stall_pct = 9;
      for (int i = 0; i < 640; i++) pending_items.push_back(random_item());
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 640; i++) pending_items.push_back(random_item());
      wait_drained();

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("complex_arithmetic_unit regression: pass");
      end else begin
         $display("complex_arithmetic_unit regression: fail");
      end
      $finish;
   end

endmodule
